// File: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// property checked at every clock edge, including reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: hw/rtl/q2e_pkg.sv
// package for the quaternion to euler angle block: widths, constants, cordic table
// no dependencies
package q2e_pkg;
  localparam int VW = 51;
  localparam int ZW = 28;
  localparam int TabLen = 24;
  localparam logic signed [ZW-1:0] HalfPiQ24 = 28'sd26353589;
  localparam logic [15:0] PiQ13 = 16'd25736;
  localparam logic [15:0] HalfPiQ13 = 16'd12868;

  typedef logic signed [VW-1:0] vec_t;
  typedef logic signed [ZW-1:0] ang_t;

  typedef struct packed {
    vec_t x;
    vec_t y;
    ang_t z;
  } cordic_t;

  function automatic ang_t atan_tab(input logic [4:0] i);
    case (i)
      5'd0: atan_tab = 28'sd13176795;
      5'd1: atan_tab = 28'sd7778716;
      5'd2: atan_tab = 28'sd4110060;
      5'd3: atan_tab = 28'sd2086331;
      5'd4: atan_tab = 28'sd1047214;
      5'd5: atan_tab = 28'sd524117;
      5'd6: atan_tab = 28'sd262123;
      5'd7: atan_tab = 28'sd131069;
      5'd8: atan_tab = 28'sd65536;
      5'd9: atan_tab = 28'sd32768;
      5'd10: atan_tab = 28'sd16384;
      5'd11: atan_tab = 28'sd8192;
      5'd12: atan_tab = 28'sd4096;
      5'd13: atan_tab = 28'sd2048;
      5'd14: atan_tab = 28'sd1024;
      5'd15: atan_tab = 28'sd512;
      5'd16: atan_tab = 28'sd256;
      5'd17: atan_tab = 28'sd128;
      5'd18: atan_tab = 28'sd64;
      5'd19: atan_tab = 28'sd32;
      5'd20: atan_tab = 28'sd16;
      5'd21: atan_tab = 28'sd8;
      5'd22: atan_tab = 28'sd4;
      5'd23: atan_tab = 28'sd2;
      default: atan_tab = '0;
    endcase
  endfunction
endpackage

// File: hw/rtl/quaternion_to_euler_angles.sv
// quaternion to euler angles: products, square root cells, cordic cells, rounding
// one item accepted every cycle while the output is not stalled
// the whole pipeline advances when the output is free; in_stall rises in the same cycle
// reset clears the valid bits only; payload registers hold no reset
// depends on q2e_pkg, q2e_isqrt_cell, q2e_cordic_cell
module quaternion_to_euler_angles
  import q2e_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] quat_w,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] roll_angle,
  output logic signed [14:0] pitch_angle,
  output logic signed [15:0] yaw_angle,
  output logic               pitch_clamped
);
  localparam int SqN = 31;
  localparam int Depth = 3 + SqN + CORDIC_STEPS + 1;

  logic en;
  logic [Depth-1:0] vld;
  assign en = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], in_valid};
    end
  end
  assign out_valid = vld[Depth-1];

  // stage 1: products
  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz, p_wy, p_zx;
  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= quat_w * quat_x; p_yz <= quat_y * quat_z; p_xx <= quat_x * quat_x;
      p_yy <= quat_y * quat_y; p_wz <= quat_w * quat_z; p_xy <= quat_x * quat_y;
      p_zz <= quat_z * quat_z; p_wy <= quat_w * quat_y; p_zx <= quat_z * quat_x;
    end
  end

  // stage 2: sums and clamp
  logic signed [34:0] rn2, rd2, yn2, yd2, s2;
  logic clamp2;
  logic signed [34:0] s_raw;
  assign s_raw = 35'sd2 * (35'(p_wy) - 35'(p_zx));
  always_ff @(posedge clk) begin
    if (en) begin
      rn2 <= 35'sd2 * (35'(p_wx) + 35'(p_yz));
      rd2 <= 35'sd1073741824 - 35'sd2 * (35'(p_xx) + 35'(p_yy));
      yn2 <= 35'sd2 * (35'(p_wz) + 35'(p_xy));
      yd2 <= 35'sd1073741824 - 35'sd2 * (35'(p_yy) + 35'(p_zz));
      if (s_raw > 35'sd1073741824) begin
        s2 <= 35'sd1073741824; clamp2 <= 1'b1;
      end else if (s_raw < -35'sd1073741824) begin
        s2 <= -35'sd1073741824; clamp2 <= 1'b1;
      end else begin
        s2 <= s_raw; clamp2 <= 1'b0;
      end
    end
  end

  // stage 3: radicand 2^60 - s^2
  logic [30:0] mag2;
  assign mag2 = s2[34] ? 31'(-s2) : 31'(s2);
  logic signed [34:0] rn3, rd3, yn3, yd3, s3;
  logic clamp3;
  logic [60:0] rad3;
  always_ff @(posedge clk) begin
    if (en) begin
      rn3 <= rn2; rd3 <= rd2; yn3 <= yn2; yd3 <= yd2; s3 <= s2; clamp3 <= clamp2;
      rad3 <= 61'(62'd1 << 60) - 61'(mag2 * mag2);
    end
  end

  // square root chain with delay lines for the other operands
  logic [60:0] sv [SqN+1];
  logic [30:0] sr [SqN+1];
  logic signed [34:0] drn [SqN+1], drd [SqN+1], dyn [SqN+1], dyd [SqN+1], dss [SqN+1];
  logic dcl [SqN+1];
  assign sv[0] = rad3;
  assign sr[0] = '0;
  assign drn[0] = rn3; assign drd[0] = rd3; assign dyn[0] = yn3;
  assign dyd[0] = yd3; assign dss[0] = s3; assign dcl[0] = clamp3;

  for (genvar g = 0; g < SqN; g++) begin : g_sq
    q2e_isqrt_cell #(.STEP(g)) u_sq (
      .clk(clk), .en(en), .v_in(sv[g]), .r_in(sr[g]), .v_out(sv[g+1]), .r_out(sr[g+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        drn[g+1] <= drn[g]; drd[g+1] <= drd[g]; dyn[g+1] <= dyn[g];
        dyd[g+1] <= dyd[g]; dss[g+1] <= dss[g]; dcl[g+1] <= dcl[g];
      end
    end
  end

  // cordic pre-rotation, combinational on the square root and delay line outputs
  function automatic cordic_t pre(input logic signed [34:0] yi, input logic signed [34:0] xi);
    cordic_t o;
    vec_t xl, yl;
    xl = VW'(xi) <<< 16;
    yl = VW'(yi) <<< 16;
    o.z = '0;
    if (xl < 0) begin
      if (yl >= 0) begin
        o.x = yl; o.y = -xl; o.z = HalfPiQ24;
      end else begin
        o.x = -yl; o.y = xl; o.z = -HalfPiQ24;
      end
    end else begin
      o.x = xl; o.y = yl;
    end
    return o;
  endfunction

  cordic_t ch [CORDIC_STEPS+1][3];
  logic zr [CORDIC_STEPS+1][3];
  logic cl [CORDIC_STEPS+1];
  assign ch[0][0] = pre(drn[SqN], drd[SqN]);
  assign ch[0][1] = pre(dss[SqN], 35'(sr[SqN]));
  assign ch[0][2] = pre(dyn[SqN], dyd[SqN]);
  assign zr[0][0] = (drn[SqN] == 0) && (drd[SqN] == 0);
  assign zr[0][1] = (dss[SqN] == 0) && (sr[SqN] == 0);
  assign zr[0][2] = (dyn[SqN] == 0) && (dyd[SqN] == 0);
  assign cl[0] = dcl[SqN];

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cd
    q2e_cordic_cell #(.STEP(g)) u_cd (
      .clk(clk), .en(en), .a_in(ch[g]), .a_out(ch[g+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        zr[g+1] <= zr[g];
        cl[g+1] <= cl[g];
      end
    end
  end

  function automatic logic [15:0] to_q13(input ang_t z, input logic zero,
                                         input logic [15:0] lim);
    logic [ZW-1:0] m;
    logic [ZW-1:0] r;
    logic [15:0] q;
    m = z[ZW-1] ? ZW'(-z) : ZW'(z);
    r = (m + ZW'(1024)) >> 11;
    q = (r > ZW'(lim)) ? lim : r[15:0];
    if (zero) q = '0;
    return z[ZW-1] ? 16'(-q) : q;
  endfunction

  logic [15:0] pq;
  assign pq = to_q13(ch[CORDIC_STEPS][1].z, zr[CORDIC_STEPS][1], HalfPiQ13);
  always_ff @(posedge clk) begin
    if (en) begin
      roll_angle <= to_q13(ch[CORDIC_STEPS][0].z, zr[CORDIC_STEPS][0], PiQ13);
      pitch_angle <= pq[14:0];
      yaw_angle <= to_q13(ch[CORDIC_STEPS][2].z, zr[CORDIC_STEPS][2], PiQ13);
      pitch_clamped <= cl[CORDIC_STEPS];
    end
  end
endmodule

// File: hw/rtl/q2e_cordic_cell.sv
// one vectoring cordic iteration for three lanes, registered
// depends on q2e_pkg
module q2e_cordic_cell
  import q2e_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic        clk,
  input  logic        en,
  input  cordic_t     a_in [3],
  output cordic_t     a_out [3]
);
  localparam logic [4:0] Idx = 5'(STEP);
  localparam ang_t Ang = atan_tab(Idx);

  cordic_t nx [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (a_in[k].y >= 0) begin
        nx[k].x = a_in[k].x + (a_in[k].y >>> STEP);
        nx[k].y = a_in[k].y - (a_in[k].x >>> STEP);
        nx[k].z = a_in[k].z + Ang;
      end else begin
        nx[k].x = a_in[k].x - (a_in[k].y >>> STEP);
        nx[k].y = a_in[k].y + (a_in[k].x >>> STEP);
        nx[k].z = a_in[k].z - Ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) a_out <= nx;
  end
endmodule

// File: hw/rtl/q2e_isqrt_cell.sv
// one restoring square root step (two radicand bits), registered
// depends on q2e_pkg
module q2e_isqrt_cell
  import q2e_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic        clk,
  input  logic        en,
  input  logic [60:0] v_in,
  input  logic [30:0] r_in,
  output logic [60:0] v_out,
  output logic [30:0] r_out
);
  localparam int Sh = 60 - 2 * STEP;
  localparam logic [61:0] Bit = 62'd1 << Sh;

  logic [61:0] rb;
  logic [61:0] rr;
  logic [61:0] v_nx;
  logic [61:0] r_nx;

  always_comb begin
    rr = {31'd0, r_in} << (Sh / 2 + 1);
    rb = rr + Bit;
    if ({1'b0, v_in} >= rb) begin
      v_nx = {1'b0, v_in} - rb;
      r_nx = (rr >> 1) + Bit;
    end else begin
      v_nx = {1'b0, v_in};
      r_nx = rr >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_out <= v_nx[60:0];
      r_out <= 31'(r_nx >> (Sh / 2));
    end
  end
endmodule

// File: hw/rtl/q2e_checker.sv
// port checker for the quaternion to euler angle block, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"
module q2e_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] roll_angle,
  input logic signed [14:0] pitch_angle,
  input logic               pitch_clamped
);
  `ASSERT_CLK(a_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(roll_angle), "result changed while stalled")
  `ASSERT_CLK(a_bp, clk, rst, in_stall |-> out_valid && out_stall, "input stalled without output back-pressure")
  `ASSERT_CLK(a_clamp, clk, rst, out_valid && pitch_clamped |-> pitch_angle == 15'sd12868 || pitch_angle == -15'sd12868, "clamped pitch not at the limit")
  `ASSERT_ALWAYS(a_rst, clk, rst |=> !out_valid, "result valid after reset")
endmodule

bind quaternion_to_euler_angles q2e_checker u_q2e_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .roll_angle(roll_angle), .pitch_angle(pitch_angle),
  .pitch_clamped(pitch_clamped)
);

// File: tb/sv/quaternion_to_euler_angles_tb.sv
// testbench for quaternion_to_euler_angles: directed table then random quaternions,
// each result checked against the table value where given, else a behavioural predictor of the fixed-point angle maths
// depends on q2e_pkg and the quaternion_to_euler_angles rtl
module quaternion_to_euler_angles_tb;
  import q2e_pkg::*;

  localparam int Steps = 16;
  localparam int Latency = 3 + 31 + Steps + 1;
  localparam int WatchLimit = 4000;
  localparam int NumRandom = 1430;
  localparam logic signed [63:0] OneQ30 = 64'sd1 << 30;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               clamped;
  } angles_t;

  typedef struct {
    logic signed [15:0] x, y, z, w;
    bit                 known;
    angles_t            ang;
  } quat_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] roll_angle;
  logic signed [14:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  logic pitch_clamped;

  angles_t angles_due[$];
  int mismatches = 0;
  int results_seen = 0;
  int clamp_seen = 0;
  int idle_cycles = 0;
  bit sending_done = 1'b0;
  bit quiet_tail = 1'b0;
  bit hold_off = 1'b0;

  quaternion_to_euler_angles #(.CORDIC_STEPS(Steps)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [63:0] floor_shift(logic signed [63:0] v, int n);
    return v >>> n;
  endfunction

  function automatic logic signed [63:0] angle_of(logic signed [63:0] yi,
                                                  logic signed [63:0] xi);
    logic signed [63:0] xa, ya, za, t, dx, dy;
    za = 0;
    if (xi == 0 && yi == 0) return 0;
    xa = xi * 65536;
    ya = yi * 65536;
    if (xa < 0) begin
      t = xa;
      if (ya >= 0) begin
        xa = ya; ya = -t; za = HalfPiQ24;
      end else begin
        xa = -ya; ya = t; za = -HalfPiQ24;
      end
    end
    for (int i = 0; i < Steps && i < TabLen; i++) begin
      dx = floor_shift(ya, i);
      dy = floor_shift(xa, i);
      if (ya >= 0) begin
        xa += dx; ya -= dy; za += atan_tab(i[4:0]);
      end else begin
        xa -= dx; ya += dy; za -= atan_tab(i[4:0]);
      end
    end
    return za;
  endfunction

  function automatic logic signed [63:0] round_q13(logic signed [63:0] v,
                                                   logic signed [63:0] lim);
    logic signed [63:0] m, r;
    m = v < 0 ? -v : v;
    r = (m + 1024) >>> 11;
    if (r > lim) r = lim;
    return v < 0 ? -r : r;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic angles_t euler_of(logic signed [15:0] qx, logic signed [15:0] qy,
                                       logic signed [15:0] qz, logic signed [15:0] qw);
    logic signed [63:0] x, y, z, w, rn, rd, yn, yd, s, c, mag;
    angles_t a;
    x = qx; y = qy; z = qz; w = qw;
    rn = 2 * (w * x + y * z);
    rd = OneQ30 - 2 * (x * x + y * y);
    yn = 2 * (w * z + x * y);
    yd = OneQ30 - 2 * (y * y + z * z);
    s = 2 * (w * y - z * x);
    a.clamped = 1'b0;
    if (s > OneQ30) begin
      s = OneQ30; a.clamped = 1'b1;
    end
    if (s < -OneQ30) begin
      s = -OneQ30; a.clamped = 1'b1;
    end
    mag = s < 0 ? -s : s;
    c = root_floor((64'd1 << 60) - mag * mag);
    a.roll = 16'(round_q13(angle_of(rn, rd), PiQ13));
    a.pitch = 15'(round_q13(angle_of(s, c), HalfPiQ13));
    a.yaw = 16'(round_q13(angle_of(yn, yd), PiQ13));
    return a;
  endfunction

  task automatic send_quat(logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z, logic signed [15:0] w,
                           bit known, angles_t ang, bit gaps);
    angles_t p;
    p = euler_of(x, y, z, w);
    if (known && p != ang)
      $display("table row %0d %0d %0d %0d disagrees with predictor", x, y, z, w);
    quat_x <= x; quat_y <= y; quat_z <= z; quat_w <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    angles_due.push_back(known ? ang : p);
    if (gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic logic signed [15:0] rand_comp(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'sd0;
      2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($signed($urandom_range(0, 46340)) - 23170);
    endcase
  endfunction

  // directed rows; expected given only where obvious
  quat_row_t table_rows[] = '{
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'sd0, 15'sd0, 16'sd0, 1'b0}},
    '{16'sd0, 16'sd0, 16'sd0, 16'sh7fff, 1'b1, '{16'sd0, 15'sd0, 16'sd0, 1'b0}},
    '{16'sd0, 16'sd0, 16'sd0, 16'sh8000, 1'b1, '{16'sd0, 15'sd0, 16'sd0, 1'b0}},
    '{16'sh7fff, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
    '{16'sd0, 16'sh7fff, 16'sd0, 16'sd0, 1'b0, '0},
    '{16'sd0, 16'sd0, 16'sh7fff, 16'sd0, 1'b0, '0},
    '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '0},
    '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, '0},
    '{16'sd0, 16'sh8000, 16'sd0, 16'sh8000, 1'b0, '0},
    '{16'sd0, 16'sh7fff, 16'sd0, 16'sh8000, 1'b0, '0},
    '{16'sd23170, 16'sd0, 16'sd0, 16'sd23170, 1'b0, '0},
    '{16'sd0, 16'sd23170, 16'sd0, 16'sd23170, 1'b0, '0},
    '{16'sd0, 16'sd23170, 16'sd0, -16'sd23170, 1'b0, '0},
    '{16'sd0, 16'sd0, 16'sd23170, 16'sd23170, 1'b0, '0},
    '{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 1'b0, '0},
    '{-16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384, 1'b0, '0},
    '{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 1'b0, '0},
    '{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 1'b0, '0},
    '{16'sd1, -16'sd1, 16'sd1, -16'sd1, 1'b0, '0},
    '{16'sh7fff, 16'sd0, 16'sd0, 16'sh7fff, 1'b0, '0}
  };

  initial begin
    logic signed [15:0] c [4];
    int mode;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (table_rows[i])
      send_quat(table_rows[i].x, table_rows[i].y, table_rows[i].z, table_rows[i].w,
                table_rows[i].known, table_rows[i].ang, 1'b0);
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom - 200) quiet_tail = 1'b1;
      mode = $urandom_range(0, 9);
      foreach (c[k]) c[k] = rand_comp(mode < 3 ? 0 : (mode < 4 ? $urandom_range(0, 2) : 3));
      send_quat(c[0], c[1], c[2], c[3], 1'b0, '0, !quiet_tail);
    end
    in_valid <= 1'b0;
    sending_done = 1'b1;
  end

  // output side: random stall bursts plus one long hold-off
  initial begin
    int wait_left;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (results_seen >= 300 && !hold_off) begin
        hold_off = 1'b1;
        out_stall <= 1'b1;
        wait_left = 3 * Latency;
        while (wait_left > 0) begin
          @(posedge clk);
          wait_left--;
        end
        out_stall <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    angles_t want, got;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      got = '{roll_angle, pitch_angle, yaw_angle, pitch_clamped};
      if (got.clamped) clamp_seen++;
      if (angles_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %p", got);
      end else begin
        want = angles_due.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: roll %0d/%0d pitch %0d/%0d yaw %0d/%0d clamp %0b/%0b",
                     want.roll, got.roll, want.pitch, got.pitch, want.yaw, got.yaw,
                     want.clamped, got.clamped);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("timeout waiting for items");
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    wait (sending_done);
    wait (angles_due.size() == 0);
    repeat (Latency + 10) @(posedge clk);
    $display("checked %0d angle sets, %0d with the pitch argument saturated",
             results_seen, clamp_seen);
    if (mismatches == 0 && angles_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/q2e_pkg.sv
hw/rtl/q2e_cordic_cell.sv
hw/rtl/q2e_isqrt_cell.sv
hw/rtl/quaternion_to_euler_angles.sv
hw/rtl/q2e_checker.sv
tb/sv/quaternion_to_euler_angles_tb.sv
